// ----- src/pbez_pkg.sv -----
package pbez_pkg;

	localparam int MAX_POINTS = 64;
	localparam int PIDX_W     = $clog2(MAX_POINTS);
	localparam int CNT_W      = 7;
	localparam int COORD_W    = 32;
	localparam int T_W        = 17;
	localparam int SEG_W      = $clog2(MAX_POINTS / 3);
	localparam int BANKS      = 4;
	localparam int BANK_DEPTH = MAX_POINTS / BANKS;
	localparam int BANK_AW    = $clog2(BANK_DEPTH);
	localparam int Q_DEPTH    = 4;
	localparam int Q_AW       = $clog2(Q_DEPTH);
	localparam int PROD_W     = 2 * COORD_W;
	localparam int SUM_W      = PROD_W + 2;
	localparam int QV_W       = SUM_W - 30;

	localparam logic [T_W-1:0]   ONE_Q16    = T_W'(65536);
	localparam logic [CNT_W-1:0] CNT_RESET  = CNT_W'(7);
	localparam logic [CNT_W-1:0] CNT_MIN    = CNT_W'(6);
	localparam logic [CNT_W-1:0] CNT_MAX    = CNT_W'(MAX_POINTS);
	localparam logic [SEG_W-1:0] SEGS_RESET = SEG_W'(int'(CNT_RESET) / 3 - 1);

	localparam logic [1:0] FUNC_LOAD    = 2'd0;
	localparam logic [1:0] FUNC_POINT   = 2'd1;
	localparam logic [1:0] FUNC_TANGENT = 2'd2;

	typedef struct packed {
		logic [1:0]         func;
		logic [PIDX_W-1:0]  point_index;
		logic [COORD_W-1:0] load_x;
		logic [COORD_W-1:0] load_y;
		logic [T_W-1:0]     t_param;
	} req_word_t;

	typedef struct packed {
		logic [COORD_W-1:0] x_out;
		logic [COORD_W-1:0] y_out;
	} rsp_word_t;

	typedef struct packed {
		logic                            is_load;
		logic                            is_eval;
		logic                            is_tan;
		logic [PIDX_W-1:0]               idx;
		logic [COORD_W-1:0]              load_x;
		logic [COORD_W-1:0]              load_y;
		logic [1:0]                      rot;
		logic [BANKS-1:0][BANK_AW-1:0]   raddr;
		logic [3:0][COORD_W-1:0]         coef;
	} job_t;

endpackage

// ----- src/pbez_ram.sv -----
module pbez_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ----- src/pbez_front.sv -----
module pbez_front (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              req_valid,
	output logic                              req_stall,
	input  pbez_pkg::req_word_t               req,
	input  logic                              cfg_we,
	input  logic [pbez_pkg::CNT_W-1:0]        cfg_data,
	output logic                              push,
	output pbez_pkg::job_t                    job,
	input  logic                              full
);

	logic [pbez_pkg::SEG_W-1:0] segs_q;
	logic [pbez_pkg::CNT_W-1:0] cnt_c;
	logic [15:0]                cnt_mul;
	logic [pbez_pkg::SEG_W-1:0] segs_n;
	logic [pbez_pkg::T_W-1:0]   t_sat;
	logic [21:0]                v;
	logic [5:0]                 seg_raw;
	logic [pbez_pkg::SEG_W-1:0] seg;
	logic [pbez_pkg::T_W-1:0]   u;
	logic [pbez_pkg::PIDX_W:0]  base;
	logic [pbez_pkg::BANKS-1:0][pbez_pkg::BANK_AW-1:0] raddr;
	logic                       fadv;

	logic                                              v_s1, v_s2, v_s3;
	pbez_pkg::req_word_t                               req_s1, req_s2;
	logic [pbez_pkg::T_W-1:0]                          u_s1, u_s2, w_s2;
	logic [1:0]                                        rot_s1, rot_s2;
	logic [pbez_pkg::PIDX_W:0]                         base_s1;
	logic [pbez_pkg::BANKS-1:0][pbez_pkg::BANK_AW-1:0] raddr_s2;
	logic [33:0]                                       ww_s2, wu_s2, uu_s2;
	pbez_pkg::job_t                                    job_s3;

	logic [pbez_pkg::T_W-1:0] w1;
	logic [52:0]              b0, b1, b2, b3;
	logic signed [31:0]       d0, d1, d2;
	pbez_pkg::job_t           job_n;

	// segment count worked out when point_count is written
	always_comb begin
		if (cfg_data < pbez_pkg::CNT_MIN) begin
			cnt_c = pbez_pkg::CNT_MIN;
		end else if (cfg_data > pbez_pkg::CNT_MAX) begin
			cnt_c = pbez_pkg::CNT_MAX;
		end else begin
			cnt_c = cfg_data;
		end
		// divide by three through the reciprocal
		cnt_mul = 16'(cnt_c) * 16'd171;
		segs_n  = pbez_pkg::SEG_W'(cnt_mul >> 9) - pbez_pkg::SEG_W'(1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			segs_q <= pbez_pkg::SEGS_RESET;
		end else if (cfg_we) begin
			segs_q <= segs_n;
		end
	end

	always_comb begin
		t_sat   = (req.t_param > pbez_pkg::ONE_Q16) ? pbez_pkg::ONE_Q16 : req.t_param;
		v       = 22'(t_sat) * 22'(segs_q);
		seg_raw = v[21:16];
		if (seg_raw >= 6'(segs_q)) begin
			seg = segs_q - pbez_pkg::SEG_W'(1);
		end else begin
			seg = pbez_pkg::SEG_W'(seg_raw);
		end
		u    = pbez_pkg::T_W'(v - (22'(seg) << 16));
		base = (pbez_pkg::PIDX_W+1)'(seg) * (pbez_pkg::PIDX_W+1)'(3)
			+ (pbez_pkg::PIDX_W+1)'(1);
	end

	always_comb begin
		for (int k = 0; k < pbez_pkg::BANKS; k++) begin
			raddr[k] = pbez_pkg::BANK_AW'((base_s1
				+ (pbez_pkg::PIDX_W+1)'(2'(2'(k) - base_s1[1:0]))) >> 2);
		end
	end

	assign fadv      = !(v_s3 && full);
	assign req_stall = !fadv;
	assign push      = v_s3 && !full;
	assign job       = job_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (fadv) begin
			v_s1 <= req_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	// stage 1: segment and local fraction
	always_ff @(posedge clk) begin
		if (fadv) begin
			req_s1  <= req;
			u_s1    <= u;
			rot_s1  <= base[1:0];
			base_s1 <= base;
		end
	end

	// stage 2: squares and cross term
	assign w1 = pbez_pkg::ONE_Q16 - u_s1;

	always_ff @(posedge clk) begin
		if (fadv) begin
			req_s2   <= req_s1;
			u_s2     <= u_s1;
			w_s2     <= w1;
			rot_s2   <= rot_s1;
			raddr_s2 <= raddr;
			ww_s2    <= 34'(w1) * 34'(w1);
			wu_s2    <= 34'(w1) * 34'(u_s1);
			uu_s2    <= 34'(u_s1) * 34'(u_s1);
		end
	end

	// stage 3: weights folded into one coefficient per point
	always_comb begin
		b0 = (53'(ww_s2) * 53'(w_s2)) >> 18;
		b1 = (53'(ww_s2) * 53'(u_s2) * 53'd3) >> 18;
		b2 = (53'(uu_s2) * 53'(w_s2) * 53'd3) >> 18;
		b3 = (53'(uu_s2) * 53'(u_s2)) >> 18;
		d0 = $signed(32'(ww_s2 >> 2));
		d1 = $signed(32'(wu_s2 >> 1));
		d2 = $signed(32'(uu_s2 >> 2));
		job_n.is_load = (req_s2.func == pbez_pkg::FUNC_LOAD);
		job_n.is_eval = (req_s2.func == pbez_pkg::FUNC_POINT)
			|| (req_s2.func == pbez_pkg::FUNC_TANGENT);
		job_n.is_tan  = (req_s2.func == pbez_pkg::FUNC_TANGENT);
		job_n.idx     = req_s2.point_index;
		job_n.load_x  = req_s2.load_x;
		job_n.load_y  = req_s2.load_y;
		job_n.rot     = rot_s2;
		job_n.raddr   = raddr_s2;
		if (req_s2.func == pbez_pkg::FUNC_TANGENT) begin
			job_n.coef[0] = 32'(-d0);
			job_n.coef[1] = 32'(d0 - d1);
			job_n.coef[2] = 32'(d1 - d2);
			job_n.coef[3] = 32'(d2);
		end else begin
			job_n.coef[0] = 32'(b0);
			job_n.coef[1] = 32'(b1);
			job_n.coef[2] = 32'(b2);
			job_n.coef[3] = 32'(b3);
		end
	end

	always_ff @(posedge clk) begin
		if (fadv) begin
			job_s3 <= job_n;
		end
	end

	a_stall_only_when_backed: assert property (@(posedge clk) disable iff (!arst_n)
		req_stall |-> (v_s3 && full))
		else $error("front stalls without a waiting word");

endmodule

// ----- src/pbez_queue.sv -----
module pbez_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  pbez_pkg::job_t push_job,
	output logic           full,
	input  logic           pop,
	output pbez_pkg::job_t head,
	output logic           empty
);

	pbez_pkg::job_t              mem_q [pbez_pkg::Q_DEPTH];
	logic [pbez_pkg::Q_AW-1:0]   wptr_q, rptr_q;
	logic [pbez_pkg::Q_AW:0]     cnt_q;

	assign full  = (cnt_q == (pbez_pkg::Q_AW+1)'(pbez_pkg::Q_DEPTH));
	assign empty = (cnt_q == '0);
	assign head  = mem_q[rptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wptr_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (push) begin
				wptr_q <= wptr_q + pbez_pkg::Q_AW'(1);
			end
			if (pop) begin
				rptr_q <= rptr_q + pbez_pkg::Q_AW'(1);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + (pbez_pkg::Q_AW+1)'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - (pbez_pkg::Q_AW+1)'(1);
			end
		end
	end

	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !full) else $error("push into full queue");
	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !empty) else $error("pop from empty queue");
	a_ptr_track: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q == '0 || full) |-> (wptr_q == rptr_q))
		else $error("queue pointers disagree with fill count");

endmodule

// ----- src/pbez_back.sv -----
module pbez_back (
	input  logic                clk,
	input  logic                arst_n,
	input  pbez_pkg::job_t      head,
	input  logic                empty,
	output logic                pop,
	output logic                rsp_valid,
	input  logic                rsp_stall,
	output pbez_pkg::rsp_word_t rsp
);

	logic adv;
	logic [pbez_pkg::BANKS-1:0][pbez_pkg::PROD_W-1:0] rdata;

	logic                                 v_s4, v_s5, v_s6;
	logic                                 eval_s4, eval_s5, eval_s6;
	logic                                 tan_s4, tan_s5, tan_s6;
	logic [1:0]                           rot_s4;
	logic [3:0][pbez_pkg::COORD_W-1:0]    coef_s4;
	logic signed [pbez_pkg::PROD_W-1:0]   px_s5 [4];
	logic signed [pbez_pkg::PROD_W-1:0]   py_s5 [4];
	logic signed [pbez_pkg::QV_W-1:0]     qx_s6, qy_s6;
	logic                                 valid_q;
	pbez_pkg::rsp_word_t                  rsp_q;

	logic signed [pbez_pkg::SUM_W-1:0]    sx, sy;
	logic signed [pbez_pkg::QV_W+1:0]     ox, oy;

	assign adv = !(valid_q && rsp_stall);
	assign pop = adv && !empty;

	for (genvar k = 0; k < pbez_pkg::BANKS; k++) begin : g_bank
		pbez_ram #(
			.WIDTH(pbez_pkg::PROD_W),
			.DEPTH(pbez_pkg::BANK_DEPTH)
		) u_ram (
			.clk  (clk),
			.we   (pop && head.is_load && (head.idx[1:0] == 2'(k))),
			.waddr(pbez_pkg::BANK_AW'(head.idx >> 2)),
			.wdata({head.load_x, head.load_y}),
			.re   (adv),
			.raddr(head.raddr[k]),
			.rdata(rdata[k])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4    <= 1'b0;
			v_s5    <= 1'b0;
			v_s6    <= 1'b0;
			valid_q <= 1'b0;
		end else if (adv) begin
			v_s4    <= pop;
			v_s5    <= v_s4;
			v_s6    <= v_s5;
			valid_q <= v_s6;
		end
	end

	// stage 4: bank read in flight
	always_ff @(posedge clk) begin
		if (adv) begin
			eval_s4 <= head.is_eval;
			tan_s4  <= head.is_tan;
			rot_s4  <= head.rot;
			coef_s4 <= head.coef;
		end
	end

	// stage 5: one product per point and coordinate
	always_ff @(posedge clk) begin
		if (adv) begin
			eval_s5 <= eval_s4;
			tan_s5  <= tan_s4;
			for (int j = 0; j < 4; j++) begin
				px_s5[j] <= $signed(coef_s4[j]) * $signed(rdata[2'(rot_s4 + 2'(j))][63:32]);
				py_s5[j] <= $signed(coef_s4[j]) * $signed(rdata[2'(rot_s4 + 2'(j))][31:0]);
			end
		end
	end

	// stage 6: sum and round to Q16.16
	always_comb begin
		sx = (pbez_pkg::SUM_W)'(px_s5[0]) + (pbez_pkg::SUM_W)'(px_s5[1])
			+ (pbez_pkg::SUM_W)'(px_s5[2]) + (pbez_pkg::SUM_W)'(px_s5[3])
			+ (pbez_pkg::SUM_W)'(1 << 29);
		sy = (pbez_pkg::SUM_W)'(py_s5[0]) + (pbez_pkg::SUM_W)'(py_s5[1])
			+ (pbez_pkg::SUM_W)'(py_s5[2]) + (pbez_pkg::SUM_W)'(py_s5[3])
			+ (pbez_pkg::SUM_W)'(1 << 29);
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			eval_s6 <= eval_s5;
			tan_s6  <= tan_s5;
			qx_s6   <= sx[pbez_pkg::SUM_W-1:30];
			qy_s6   <= sy[pbez_pkg::SUM_W-1:30];
		end
	end

	function automatic logic [31:0] sat32(input logic signed [pbez_pkg::QV_W+1:0] a);
		logic [31:0] r;
		if (a > $signed((pbez_pkg::QV_W+2)'(32'h7fff_ffff))) begin
			r = 32'h7fff_ffff;
		end else if (a < -$signed((pbez_pkg::QV_W+2)'(33'h0_8000_0000))) begin
			r = 32'h8000_0000;
		end else begin
			r = a[31:0];
		end
		return r;
	endfunction

	// output word: tangent scaled by three, then saturate
	always_comb begin
		if (tan_s6) begin
			ox = (pbez_pkg::QV_W+2)'(qx_s6) + ((pbez_pkg::QV_W+2)'(qx_s6) <<< 1);
			oy = (pbez_pkg::QV_W+2)'(qy_s6) + ((pbez_pkg::QV_W+2)'(qy_s6) <<< 1);
		end else begin
			ox = (pbez_pkg::QV_W+2)'(qx_s6);
			oy = (pbez_pkg::QV_W+2)'(qy_s6);
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			rsp_q.x_out <= eval_s6 ? sat32(ox) : '0;
			rsp_q.y_out <= eval_s6 ? sat32(oy) : '0;
		end
	end

	assign rsp_valid = valid_q;
	assign rsp       = rsp_q;

endmodule

// ----- src/piecewise_cubic_bezier_eval.sv -----
// throughput: one word per cycle, loads and evaluations alike, while neither a full queue nor rsp_stall holds the flow
// a three-stage front feeds a four-entry queue; the back reads four point banks at once
// reset clears the pipeline valids, the queue and point_count (to 7)
// the point store is not cleared; an entry reads as undefined until loaded
module piecewise_cubic_bezier_eval (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       req_valid,
	output logic                       req_stall,
	input  pbez_pkg::req_word_t        req,
	output logic                       rsp_valid,
	input  logic                       rsp_stall,
	output pbez_pkg::rsp_word_t        rsp,
	input  logic                       cfg_we,
	input  logic [pbez_pkg::CNT_W-1:0] cfg_data
);

	logic           push, full, pop, empty;
	pbez_pkg::job_t job, head;

	pbez_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req      (req),
		.cfg_we   (cfg_we),
		.cfg_data (cfg_data),
		.push     (push),
		.job      (job),
		.full     (full)
	);

	pbez_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.push_job(job),
		.full    (full),
		.pop     (pop),
		.head    (head),
		.empty   (empty)
	);

	pbez_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.head     (head),
		.empty    (empty),
		.pop      (pop),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp      (rsp)
	);

endmodule
